### rtl/core/arec_pkg.sv
// Shared types and constants of the accelerated rotary encoder counter.
`default_nettype none

package arec_pkg;

	localparam int CMD_W   = 2;
	localparam int TICK_W  = 32;
	localparam int POS_W   = 32;
	localparam int CFG_W   = 8;
	localparam int CFG_IDX_W = 8;

	localparam int DIV_STEPS = CFG_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = CFG_W'(5);
	localparam logic [CFG_W-1:0] SPEED_NUM_RST    = CFG_W'(200);
	localparam logic [CFG_W-1:0] STEP_MIN         = CFG_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_EDGE   = 2'd0,
		CMD_BUTTON = 2'd1,
		CMD_READ   = 2'd2
	} arec_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_INTERVAL = 8'd0,
		REG_SPEED_NUM    = 8'd1
	} arec_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_APPLY
	} arec_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic div_step;
		logic commit;
	} arec_ctl_t;

	typedef struct packed {
		logic take_edge;
	} arec_stat_t;

endpackage

`default_nettype wire

### rtl/core/arec_ifs.sv
// Channel interfaces: input items, result items and register writes.
`default_nettype none

interface arec_in_if;
	import arec_pkg::*;
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    cmd;
	logic [TICK_W-1:0]   now_tick;
	logic                direction_level;
	logic                button_level;

	modport source (output valid, cmd, now_tick, direction_level, button_level, input ready);
	modport sink   (input valid, cmd, now_tick, direction_level, button_level, output ready);
endinterface

interface arec_out_if;
	import arec_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] position;
	logic                    button_pressed;

	modport source (output valid, position, button_pressed, input ready);
	modport sink   (input valid, position, button_pressed, output ready);
endinterface

interface arec_cfg_if;
	import arec_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/accelerated_rotary_encoder_counter.sv
// Top level of the accelerated rotary encoder counter with button press latch.
//
//   channel  dir  payload                                        transaction
//   req      in   cmd, now_tick, direction_level, button_level   valid & ready
//   rsp      out  position, button_pressed                       valid & ready
//   cfg      in   index, data                                    valid & ready
//
// An accepted encoder edge runs load, evaluate, 8 divide steps of the restoring
// divider and commit; an ignored edge or any other command runs load, evaluate, commit.
// One item is in work at a time; req is ready again once the result is in the
// output register, so a stalled rsp holds only the next item's commit.
// Reset clears count, last edge tick, button state and loads register defaults.
`default_nettype none

module accelerated_rotary_encoder_counter (
	input wire logic clk,
	input wire logic arst_n,
	arec_in_if.sink     req,
	arec_out_if.source  rsp,
	arec_cfg_if.sink    cfg
);
	import arec_pkg::*;

	arec_ctl_t  ctl;
	arec_stat_t stat;
	logic       req_ready;
	logic       rsp_valid;

	assign cfg.ready = 1'b1;
	assign req.ready = req_ready;
	assign rsp.valid = rsp_valid;

	arec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req_ready),
		.out_valid (rsp_valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	arec_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.cmd             (req.cmd),
		.now_tick        (req.now_tick),
		.direction_level (req.direction_level),
		.button_level    (req.button_level),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.position        (rsp.position),
		.button_pressed  (rsp.button_pressed)
	);

endmodule

`default_nettype wire

### rtl/core/arec_ctrl.sv
// Controller: sequences load, evaluate, divide and commit of one item.
`default_nettype none

module arec_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire arec_pkg::arec_stat_t stat,
	output arec_pkg::arec_ctl_t  ctl
);
	import arec_pkg::*;

	arec_state_t          state_q;
	arec_state_t          state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				ctl.eval  = 1'b1;
				state_nxt = stat.take_edge ? ST_DIV : ST_APPLY;
			end
			ST_DIV: begin
				ctl.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (!out_valid_q || out_ready) begin
					ctl.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// clear the divide step count on evaluate, advance it on each divide step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.eval) begin
			cnt_q <= '0;
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/arec_dp.sv
// Datapath: registers, elapsed-tick check, restoring divider and count update.
`default_nettype none

module arec_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire arec_pkg::arec_ctl_t           ctl,
	output arec_pkg::arec_stat_t               stat,
	input  wire logic [arec_pkg::CMD_W-1:0]    cmd,
	input  wire logic [arec_pkg::TICK_W-1:0]   now_tick,
	input  wire logic                          direction_level,
	input  wire logic                          button_level,
	input  wire logic                          cfg_we,
	input  wire logic [arec_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [arec_pkg::CFG_W-1:0]    cfg_data,
	output logic signed [arec_pkg::POS_W-1:0]  position,
	output logic                               button_pressed
);
	import arec_pkg::*;

	logic [CMD_W-1:0]  cmd_q;
	logic [TICK_W-1:0] now_q;
	logic              dir_q;
	logic              lvl_q;

	logic [CFG_W-1:0]  min_q;
	logic [CFG_W-1:0]  num_q;

	logic [POS_W-1:0]  count_q;
	logic [TICK_W-1:0] last_q;
	logic              held_q;
	logic              latch_q;

	logic [CFG_W-1:0]  rem_q;
	logic [CFG_W-1:0]  quo_q;
	logic [CFG_W-1:0]  dsr_q;
	logic              big_q;
	logic              take_q;

	logic [POS_W-1:0]  pos_q;
	logic              pressed_q;

	logic [TICK_W-1:0] elapsed;
	logic              take;
	logic [CFG_W:0]    rem_sh;
	logic [CFG_W:0]    rem_sub;
	logic [CFG_W-1:0]  step;
	logic [POS_W-1:0]  count_nxt;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			now_q <= now_tick;
			dir_q <= direction_level;
			lvl_q <= button_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_INTERVAL_RST;
			num_q <= SPEED_NUM_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_INTERVAL) begin
				min_q <= cfg_data;
			end
			if (cfg_index == REG_SPEED_NUM) begin
				num_q <= cfg_data;
			end
		end
	end

	assign elapsed        = now_q - last_q;
	assign take           = (cmd_q == CMD_EDGE) && (elapsed >= TICK_W'(min_q));
	assign stat.take_edge = take;

	assign rem_sh  = {rem_q, quo_q[CFG_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			rem_q  <= '0;
			quo_q  <= num_q;
			dsr_q  <= (elapsed == '0) ? CFG_W'(1) : elapsed[CFG_W-1:0];
			big_q  <= |elapsed[TICK_W-1:CFG_W];
			take_q <= take;
		end else if (ctl.div_step) begin
			if (rem_sh >= {1'b0, dsr_q}) begin
				rem_q <= rem_sub[CFG_W-1:0];
				quo_q <= {quo_q[CFG_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[CFG_W-1:0];
				quo_q <= {quo_q[CFG_W-2:0], 1'b0};
			end
		end
	end

	assign step = (big_q || quo_q == '0) ? STEP_MIN : quo_q;

	always_comb begin
		count_nxt = count_q;
		if (take_q) begin
			count_nxt = dir_q ? count_q + POS_W'(step) : count_q - POS_W'(step);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			last_q  <= '0;
			held_q  <= 1'b0;
			latch_q <= 1'b0;
		end else if (ctl.commit) begin
			count_q <= count_nxt;
			if (take_q) begin
				last_q <= now_q;
			end
			unique case (cmd_q)
				CMD_BUTTON: begin
					if (!lvl_q) begin
						if (!held_q) begin
							latch_q <= 1'b1;
							held_q  <= 1'b1;
						end
					end else begin
						held_q <= 1'b0;
					end
				end
				CMD_READ: begin
					latch_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			pos_q     <= count_nxt;
			pressed_q <= (cmd_q == CMD_READ) ? latch_q : 1'b0;
		end
	end

	assign position       = $signed(pos_q);
	assign button_pressed = pressed_q;

endmodule

`default_nettype wire

### tb/sv/accelerated_rotary_encoder_counter_tb.sv
// Self-checking testbench of the accelerated rotary encoder counter.
module accelerated_rotary_encoder_counter_tb;
	import arec_pkg::*;

	localparam int RESET_CYCLES = 7;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 100;
	localparam logic [CMD_W-1:0] CMD_UNUSED = CMD_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED = {CFG_IDX_W{1'b1}};

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic [TICK_W-1:0] tick;
		logic              dir;
		logic              btn;
	} encoder_item_t;

	typedef struct {
		logic [POS_W-1:0] position;
		logic             button_pressed;
	} reading_t;

	typedef enum {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		encoder_item_t     item;
		logic              typed;
		reading_t          want;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [CFG_W-1:0]  reg_data;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	arec_in_if  req_if ();
	arec_out_if rsp_if ();
	arec_cfg_if cfg_if ();

	accelerated_rotary_encoder_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg(cfg_if)
	);

	always #5 clk = ~clk;

	logic [POS_W-1:0]  count_now;
	logic [TICK_W-1:0] edge_tick_last;
	logic              button_down;
	logic              press_seen;
	logic [CFG_W-1:0]  min_gap;
	logic [CFG_W-1:0]  step_numerator;

	reading_t  expected_readings[$];
	stim_row_t stim_rows[$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	bit        send_idle_on = 1'b1;
	bit        recv_idle_on = 1'b1;

	function automatic reading_t predict_reading(encoder_item_t it);
		logic [TICK_W-1:0] elapsed;
		logic [TICK_W-1:0] divisor;
		logic [TICK_W-1:0] step;
		reading_t r;
		r.button_pressed = 1'b0;
		if (it.cmd == CMD_EDGE) begin
			elapsed = it.tick - edge_tick_last;
			if (elapsed >= min_gap) begin
				divisor = (elapsed == 0) ? 1 : elapsed;
				step = step_numerator / divisor;
				if (step == 0)
					step = 1;
				count_now = it.dir ? count_now + step : count_now - step;
				edge_tick_last = it.tick;
			end
		end else if (it.cmd == CMD_BUTTON) begin
			if (!it.btn) begin
				if (!button_down) begin
					press_seen = 1'b1;
					button_down = 1'b1;
				end
			end else begin
				button_down = 1'b0;
			end
		end else if (it.cmd == CMD_READ) begin
			r.button_pressed = press_seen;
			press_seen = 1'b0;
		end
		r.position = count_now;
		return r;
	endfunction

	function automatic void push_item(logic [CMD_W-1:0] cmd, logic [TICK_W-1:0] tick, logic dir,
			logic btn, logic typed, logic [POS_W-1:0] pos, logic pressed);
		stim_row_t row;
		row.kind = ROW_ITEM;
		row.item = '{cmd, tick, dir, btn};
		row.typed = typed;
		row.want = '{pos, pressed};
		row.reg_index = '0;
		row.reg_data = '0;
		stim_rows.push_back(row);
	endfunction

	function automatic void push_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		stim_row_t row;
		row.kind = ROW_WRITE;
		row.item = '{CMD_EDGE, '0, 1'b0, 1'b0};
		row.typed = 1'b0;
		row.want = '{'0, 1'b0};
		row.reg_index = idx;
		row.reg_data = val;
		stim_rows.push_back(row);
	endfunction

	function automatic logic [CFG_W-1:0] pick_reg_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return CFG_W'(1);
			2: return {CFG_W{1'b1}};
			default: return CFG_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void note_mismatch(string field, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
	endfunction

	task automatic send_item(encoder_item_t it, logic typed, reading_t want);
		int gap;
		reading_t got;
		gap = send_idle_on ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.cmd = it.cmd;
		req_if.now_tick = it.tick;
		req_if.direction_level = it.dir;
		req_if.button_level = it.btn;
		req_if.valid = 1'b1;
		do @(posedge clk); while (!req_if.ready);
		got = predict_reading(it);
		expected_readings.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_if.valid = 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		wait_drained();
		cfg_if.index = idx;
		cfg_if.data = val;
		cfg_if.valid = 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == REG_MIN_INTERVAL)
			min_gap = val;
		else if (idx == REG_SPEED_NUM)
			step_numerator = val;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("accelerated_rotary_encoder_counter_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int stall;
		reading_t want;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = recv_idle_on ? $urandom_range(0, 4) : 0;
			if (stall != 0) begin
				rsp_if.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_if.ready = 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			if (expected_readings.size() == 0) begin
				note_mismatch("unexpected result", '0, rsp_if.position);
			end else begin
				want = expected_readings.pop_front();
				if (rsp_if.position !== want.position)
					note_mismatch("position", want.position, rsp_if.position);
				if (rsp_if.button_pressed !== want.button_pressed)
					note_mismatch("button_pressed", POS_W'(want.button_pressed),
						POS_W'(rsp_if.button_pressed));
			end
			@(negedge clk);
		end
	end

	initial begin
		encoder_item_t it;
		reading_t none;
		int sel;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_EDGE;
		req_if.now_tick = '0;
		req_if.direction_level = 1'b0;
		req_if.button_level = 1'b1;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MIN_INTERVAL;
		cfg_if.data = '0;
		count_now = '0;
		edge_tick_last = '0;
		button_down = 1'b0;
		press_seen = 1'b0;
		min_gap = MIN_INTERVAL_RST;
		step_numerator = SPEED_NUM_RST;
		none = '{'0, 1'b0};

		push_item(CMD_READ, 32'h0, 1'b0, 1'b1, 1'b1, 32'd0, 1'b0);
		push_item(CMD_EDGE, 32'h3, 1'b1, 1'b1, 1'b1, 32'd0, 1'b0);
		push_item(CMD_EDGE, 32'h5, 1'b1, 1'b0, 1'b1, 32'd40, 1'b0);
		push_item(CMD_EDGE, 32'h6, 1'b0, 1'b1, 1'b1, 32'd40, 1'b0);
		push_item(CMD_EDGE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'd39, 1'b0);
		push_item(CMD_EDGE, 32'h4, 1'b1, 1'b1, 1'b1, 32'd79, 1'b0);
		push_item(CMD_BUTTON, 32'h0, 1'b0, 1'b0, 1'b1, 32'd79, 1'b0);
		push_item(CMD_BUTTON, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 32'd79, 1'b0);
		push_item(CMD_READ, 32'h0, 1'b0, 1'b0, 1'b1, 32'd79, 1'b1);
		push_item(CMD_READ, 32'h0, 1'b0, 1'b1, 1'b1, 32'd79, 1'b0);
		push_item(CMD_BUTTON, 32'h0, 1'b0, 1'b1, 1'b1, 32'd79, 1'b0);
		push_item(CMD_BUTTON, 32'h0, 1'b0, 1'b0, 1'b1, 32'd79, 1'b0);
		push_item(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd79, 1'b0);
		push_item(CMD_READ, 32'h0, 1'b0, 1'b0, 1'b1, 32'd79, 1'b1);
		push_item(CMD_EDGE, 32'h8000_0004, 1'b0, 1'b0, 1'b1, 32'd78, 1'b0);
		push_write(REG_MIN_INTERVAL, 8'h00);
		push_write(REG_SPEED_NUM, 8'hFF);
		push_item(CMD_EDGE, 32'h8000_0004, 1'b1, 1'b0, 1'b0, '0, 1'b0);
		push_item(CMD_EDGE, 32'h8000_0005, 1'b0, 1'b0, 1'b0, '0, 1'b0);
		push_item(CMD_EDGE, 32'h8000_0005, 1'b0, 1'b0, 1'b0, '0, 1'b0);
		push_write(REG_SPEED_NUM, 8'h00);
		push_item(CMD_EDGE, 32'h8000_0006, 1'b0, 1'b0, 1'b0, '0, 1'b0);
		push_write(REG_MIN_INTERVAL, 8'hFF);
		push_item(CMD_EDGE, 32'h8000_0104, 1'b1, 1'b0, 1'b0, '0, 1'b0);
		push_item(CMD_EDGE, 32'h8000_0105, 1'b1, 1'b0, 1'b0, '0, 1'b0);
		push_write(REG_LAST_UNUSED, 8'hFF);
		push_item(CMD_READ, 32'h8000_0105, 1'b1, 1'b1, 1'b0, '0, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE)
				write_reg(stim_rows[i].reg_index, stim_rows[i].reg_data);
			else
				send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			write_reg(REG_MIN_INTERVAL, pick_reg_value());
			write_reg(REG_SPEED_NUM, pick_reg_value());
			if (phase % 3 == 1)
				write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
					CFG_W'($urandom_range(0, 255)));
			send_idle_on = (phase % 3 != 0);
			recv_idle_on = (phase % 2 != 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				sel = $urandom_range(0, 99);
				it.tick = $urandom();
				it.dir = 1'($urandom_range(0, 1));
				it.btn = 1'($urandom_range(0, 1));
				if (sel < 60) begin
					it.cmd = CMD_EDGE;
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4:
							it.tick = edge_tick_last + $urandom_range(0, min_gap + 16);
						5, 6, 7: it.tick = edge_tick_last + $urandom_range(0, 600);
						8: ;
						default: it.tick = edge_tick_last - $urandom_range(1, 16);
					endcase
				end else if (sel < 78) begin
					it.cmd = CMD_BUTTON;
				end else if (sel < 93) begin
					it.cmd = CMD_READ;
				end else begin
					it.cmd = CMD_UNUSED;
				end
				send_item(it, 1'b0, none);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("accelerated_rotary_encoder_counter_tb: clean");
		else
			$display("accelerated_rotary_encoder_counter_tb: errors");
		$finish;
	end

endmodule

### files.f
rtl/core/arec_pkg.sv
rtl/core/arec_ifs.sv
rtl/core/arec_ctrl.sv
rtl/core/arec_dp.sv
rtl/core/accelerated_rotary_encoder_counter.sv
tb/sv/accelerated_rotary_encoder_counter_tb.sv
